// ----- src/m3inv_pkg.sv -----
package m3inv_pkg;

  // element format
  localparam int ElemW = 32;
  localparam int FracB = 16;

  // exact intermediate widths
  localparam int CofW  = 2 * ElemW;           // cofactor, signed
  localparam int PlW   = 2 * ElemW + 1;       // element times unsigned low half
  localparam int DetW  = 3 * ElemW + 1;       // determinant, signed
  localparam int NumA  = 2 * ElemW + 2 * FracB + 1;
  localparam int NumW  = ((NumA > DetW) ? NumA : DetW) + 1;

  // pipeline layout: five front stages, ElemW+1 divide steps, one output stage
  localparam int FrontN = 5;
  localparam int DivN   = ElemW + 1;
  localparam int StageN = FrontN + DivN + 1;

  typedef logic signed [ElemW-1:0] elem_t;

  // one divide lane's working word
  typedef struct packed {
    logic [NumW-1:0]  rem;
    logic [NumW-1:0]  dvs;
    logic [ElemW-1:0] quo;
    logic             ovf;
    logic             neg;
  } lane_t;

endpackage

// ----- src/m3inv_if.sv -----
interface m3inv_in_if;
  import m3inv_pkg::*;
  logic  valid;
  logic  ready;
  elem_t in_r0c0, in_r0c1, in_r0c2;
  elem_t in_r1c0, in_r1c1, in_r1c2;
  elem_t in_r2c0, in_r2c1, in_r2c2;

  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink   (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface m3inv_out_if;
  import m3inv_pkg::*;
  logic  valid;
  logic  ready;
  elem_t out_r0c0, out_r0c1, out_r0c2;
  elem_t out_r1c0, out_r1c1, out_r1c2;
  elem_t out_r2c0, out_r2c1, out_r2c2;
  logic  singular;
  logic  clipped;

  modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                  out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, clipped, input ready);
  modport sink   (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                  out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, clipped, output ready);
endinterface

// ----- src/m3inv_div_lane.sv -----
module m3inv_div_lane
  import m3inv_pkg::*;
(
  input  logic              clk_i,
  input  logic [DivN-1:0]   en_i,
  input  lane_t             lane_i,
  output lane_t             lane_o
);

  lane_t stg_q [DivN];
  lane_t stg_d [DivN];

  // one quotient bit per stage, restoring; the first stage only checks overflow
  always_comb begin
    for (int s = 0; s < DivN; s++) begin
      lane_t src;
      logic  ge;
      src = (s == 0) ? lane_i : stg_q[(s == 0) ? 0 : s - 1];
      ge  = (src.rem >> (ElemW - s)) >= src.dvs;
      stg_d[s] = src;
      if (s == 0) begin
        stg_d[s].ovf = ge;
        stg_d[s].quo = '0;
      end else if (ge) begin
        stg_d[s].rem = src.rem - (src.dvs << (ElemW - s));
        stg_d[s].quo[(s == 0) ? 0 : ElemW - s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DivN; s++) begin
      if (en_i[s]) stg_q[s] <= stg_d[s];
    end
  end

  assign lane_o = stg_q[DivN-1];

endmodule

// ----- src/matrix3_inverse_core.sv -----
// 3x3 matrix inverse, signed fixed point (ElemW bits, FracB fraction bits).
// inp_i takes one matrix per transfer; res_o gives its inverse, formed as
// the adjugate over the determinant, each element rounded to nearest (ties
// away from zero) and saturated, with clipped set if any element saturated.
// A zero determinant gives all-zero elements with singular set.
// Throughput: one matrix per cycle while res_o is ready.
// Five stages form products, cofactors, determinant and divide operands,
// then ElemW+1 restoring divide steps per element, one quotient bit each,
// then one saturation and output register.
// Each stage has its own valid bit; a stage loads when it is empty or the
// stage after it moves, so bubbles close up and a stalled receiver holds
// the result while inp_i keeps accepting until the pipeline is full.
// Nothing is lost or repeated under stall.
// Reset clears all valid bits; the block carries no state between items.
module matrix3_inverse_core
  import m3inv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  m3inv_in_if.sink    inp_i,
  m3inv_out_if.source res_o
);

  logic [StageN-1:0] vld_q;
  logic [StageN-1:0] en;

  // stage enables, from the output back
  always_comb begin
    en[StageN-1] = !vld_q[StageN-1] || res_o.ready;
    for (int k = StageN - 2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < StageN; k++) begin
        if (en[k]) vld_q[k] <= (k == 0) ? inp_i.valid : vld_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign inp_i.ready = en[0];

  elem_t a [9];
  assign a[0] = inp_i.in_r0c0;  assign a[1] = inp_i.in_r0c1;  assign a[2] = inp_i.in_r0c2;
  assign a[3] = inp_i.in_r1c0;  assign a[4] = inp_i.in_r1c1;  assign a[5] = inp_i.in_r1c2;
  assign a[6] = inp_i.in_r2c0;  assign a[7] = inp_i.in_r2c1;  assign a[8] = inp_i.in_r2c2;

  // stage 1: cofactor products
  logic signed [CofW-1:0] p1_q [9], p2_q [9];
  elem_t                  a0_1q [3];
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p1_q[i*3+j] <= a[((i+1)%3)*3 + (j+1)%3] * a[((i+2)%3)*3 + (j+2)%3];
          p2_q[i*3+j] <= a[((i+1)%3)*3 + (j+2)%3] * a[((i+2)%3)*3 + (j+1)%3];
        end
      end
      for (int j = 0; j < 3; j++) a0_1q[j] <= a[j];
    end
  end

  // stage 2: cofactors
  logic signed [CofW-1:0] cof2_q [9];
  elem_t                  a0_2q [3];
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < 9; k++) cof2_q[k] <= p1_q[k] - p2_q[k];
      for (int j = 0; j < 3; j++) a0_2q[j] <= a0_1q[j];
    end
  end

  // stage 3: row-0 terms split into high and low partial products
  logic signed [CofW-1:0] ph_q [3];
  logic signed [PlW-1:0]  pl_q [3];
  logic signed [CofW-1:0] cof3_q [9];
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int j = 0; j < 3; j++) begin
        ph_q[j] <= a0_2q[j] * $signed(cof2_q[j][CofW-1:ElemW]);
        pl_q[j] <= a0_2q[j] * $signed({1'b0, cof2_q[j][ElemW-1:0]});
      end
      for (int k = 0; k < 9; k++) cof3_q[k] <= cof2_q[k];
    end
  end

  // stage 4: determinant
  logic signed [DetW-1:0] det_d, det_q;
  logic signed [CofW-1:0] cof4_q [9];
  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DetW'(ph_q[j]) <<< ElemW) + DetW'(pl_q[j]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      det_q <= det_d;
      for (int k = 0; k < 9; k++) cof4_q[k] <= cof3_q[k];
    end
  end

  // stage 5: magnitudes and rounded divide operands, adjugate transpose here
  lane_t           lane5_q [9];
  logic            sing5_q;
  logic [DetW-1:0] mag_det;
  assign mag_det = det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      sing5_q <= (det_q == '0);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          logic signed [CofW-1:0] c;
          logic [CofW-1:0]        mk;
          c  = cof4_q[j*3+i];
          mk = c[CofW-1] ? CofW'(-c) : CofW'(c);
          lane5_q[i*3+j].rem <= (NumW'(mk) << (2 * FracB + 1)) + NumW'(mag_det);
          lane5_q[i*3+j].dvs <= NumW'(mag_det) << 1;
          lane5_q[i*3+j].quo <= '0;
          lane5_q[i*3+j].ovf <= 1'b0;
          lane5_q[i*3+j].neg <= c[CofW-1] ^ det_q[DetW-1];
        end
      end
    end
  end

  // divide lanes
  lane_t lane_res [9];
  for (genvar g = 0; g < 9; g++) begin : g_lane
    m3inv_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en[FrontN +: DivN]),
      .lane_i (lane5_q[g]),
      .lane_o (lane_res[g])
    );
  end

  // singular flag rides alongside the lanes
  logic [DivN-1:0] sing_q;
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DivN; s++) begin
      if (en[FrontN+s]) sing_q[s] <= (s == 0) ? sing5_q : sing_q[(s == 0) ? 0 : s - 1];
    end
  end

  // output stage: sign, saturation, singular masking
  elem_t res_d [9];
  logic  clip_d;
  always_comb begin
    clip_d = 1'b0;
    for (int k = 0; k < 9; k++) begin
      logic over;
      if (lane_res[k].neg) begin
        over     = lane_res[k].ovf ||
                   (lane_res[k].quo > {1'b1, {(ElemW-1){1'b0}}});
        res_d[k] = over ? {1'b1, {(ElemW-1){1'b0}}} : ElemW'(-lane_res[k].quo);
      end else begin
        over     = lane_res[k].ovf || lane_res[k].quo[ElemW-1];
        res_d[k] = over ? {1'b0, {(ElemW-1){1'b1}}} : ElemW'(lane_res[k].quo);
      end
      if (sing_q[DivN-1]) res_d[k] = '0;
      else clip_d = clip_d | over;
    end
  end

  elem_t res_q [9];
  logic  sing_o_q, clip_q;
  always_ff @(posedge clk_i) begin
    if (en[StageN-1]) begin
      for (int k = 0; k < 9; k++) res_q[k] <= res_d[k];
      sing_o_q <= sing_q[DivN-1];
      clip_q   <= clip_d;
    end
  end

  assign res_o.valid    = vld_q[StageN-1];
  assign res_o.out_r0c0 = res_q[0];
  assign res_o.out_r0c1 = res_q[1];
  assign res_o.out_r0c2 = res_q[2];
  assign res_o.out_r1c0 = res_q[3];
  assign res_o.out_r1c1 = res_q[4];
  assign res_o.out_r1c2 = res_q[5];
  assign res_o.out_r2c0 = res_q[6];
  assign res_o.out_r2c1 = res_q[7];
  assign res_o.out_r2c2 = res_q[8];
  assign res_o.singular = sing_o_q;
  assign res_o.clipped  = clip_q;

endmodule

// ----- src/m3inv_checker.sv -----
module m3inv_checker
  import m3inv_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input logic [9*ElemW-1:0] out_elems,
  input logic               singular,
  input logic               clipped
);

  localparam logic [ElemW-1:0] MaxPos = {1'b0, {(ElemW-1){1'b1}}};
  localparam logic [ElemW-1:0] MaxNeg = {1'b1, {(ElemW-1){1'b0}}};

  logic any_lim;
  always_comb begin
    any_lim = 1'b0;
    for (int k = 0; k < 9; k++) begin
      any_lim = any_lim || (out_elems[k*ElemW +: ElemW] == MaxPos) ||
                (out_elems[k*ElemW +: ElemW] == MaxNeg);
    end
  end

  // singular result: zero matrix, never clipped
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && singular |-> out_elems == '0 && !clipped)
    else $error("singular result not zero or flagged clipped");

  // clipped result carries at least one saturated element
  a_clip_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && clipped |-> any_lim)
    else $error("clipped set with no element at a limit");

  // stalled result stays offered
  a_hold_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_elems) && $stable(singular) && $stable(clipped))
    else $error("result changed while stalled");

endmodule

bind matrix3_inverse_core m3inv_checker u_m3inv_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_elems ({res_o.out_r2c2, res_o.out_r2c1, res_o.out_r2c0,
               res_o.out_r1c2, res_o.out_r1c1, res_o.out_r1c0,
               res_o.out_r0c2, res_o.out_r0c1, res_o.out_r0c0}),
  .singular  (res_o.singular),
  .clipped   (res_o.clipped)
);
